// File: design/skrf_pkg.sv
// Shared constants and types for the scalar Kalman rate fusion block.
`default_nettype none

package skrf_pkg;

   localparam int CSR_IDX_W = 2;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type CSR_PROCESS_VAR = 2'd0;
   localparam csr_idx_type CSR_SENSOR_VAR  = 2'd1;
   localparam csr_idx_type CSR_INITIAL_VAR = 2'd2;

   // req_tuser codes
   localparam logic CMD_GYRO     = 1'b0;
   localparam logic CMD_ODOMETRY = 1'b1;

endpackage

`default_nettype wire

// File: design/scalar_kalman_rate_fusion.sv
// Scalar Kalman filter fusing odometry and gyro yaw rates on one shared adder.
// A gyro beat or the first odometry beat is absorbed in the idle state with no result;
// a later odometry beat runs the sequencer and raises rsp_tvalid from the result state,
// which waits while an unread result holds the output register.
// One item at a time: no new beat is accepted until the current odometry beat finishes.
// Reset (synchronous, active high) loads the register defaults and clears the filter state.
`default_nettype none

module scalar_kalman_rate_fusion #(
   parameter int DATA_WIDTH    = 32,
   parameter int FRACTION_BITS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // slave side
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [((DATA_WIDTH+7)/8)*8-1:0]     req_tdata,  // angular_rate
   input  wire logic                                req_tuser,  // cmd
   // master side
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [((2*DATA_WIDTH+7)/8)*8-1:0]        rsp_tdata,  // fused_rate, estimate_variance
   // configuration
   input  wire logic                                csr_we,
   input  wire skrf_pkg::csr_idx_type               csr_addr,
   input  wire logic [DATA_WIDTH-1:0]               csr_wdata
);

   localparam int DW = DATA_WIDTH;
   localparam int AW = 2*DW + 2;
   localparam int CW = $clog2(DW);
   localparam int OW = ((2*DW+7)/8)*8;

   localparam logic [63:0] UMAX64 = (64'd1 << DW) - 64'd1;
   localparam logic [63:0] PV_WIDE = 64'd4 << FRACTION_BITS;
   localparam logic [63:0] SV_WIDE = 64'd1 << (FRACTION_BITS - 1);
   localparam logic [63:0] IV_WIDE = 64'd1000 << FRACTION_BITS;
   localparam logic [DW-1:0] PV_RESET = (PV_WIDE > UMAX64) ? '1 : PV_WIDE[DW-1:0];
   localparam logic [DW-1:0] SV_RESET = (SV_WIDE > UMAX64) ? '1 : SV_WIDE[DW-1:0];
   localparam logic [DW-1:0] IV_RESET = (IV_WIDE > UMAX64) ? '1 : IV_WIDE[DW-1:0];

   localparam logic [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};
   localparam logic [CW-1:0] LAST_STEP = CW'(DW - 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_MEAN,
      ST_VAR,
      ST_DEN,
      ST_MUL,
      ST_CMB_A,
      ST_CMB_B,
      ST_DIV_CHK,
      ST_DIV,
      ST_DIV_END,
      ST_RESULT
   } state_type;

   typedef enum logic [1:0] {
      JOB_T1,   // sensor_variance * |mean|
      JOB_T2,   // variance * |gyro|, then mean divide
      JOB_T3    // variance * sensor_variance, then variance divide
   } job_type;

   state_type        state_ff;
   job_type          job_ff;
   logic [CW-1:0]    cnt_ff;
   logic             first_ff;
   logic             rsp_tvalid_ff;
   logic [DW-1:0]    fused_ff;
   logic [DW-1:0]    evar_ff;

   logic [DW-1:0]    pv_ff;
   logic [DW-1:0]    sv_ff;
   logic [DW-1:0]    iv_ff;

   logic [DW-1:0]    mean_ff;
   logic [DW-1:0]    var_ff;
   logic [DW-1:0]    last_ff;
   logic [DW-1:0]    gyro_ff;

   logic [DW-1:0]    rate_ff;
   logic [DW-1:0]    tmp_ff;
   logic [DW-1:0]    den_ff;
   logic [DW-1:0]    mcand_ff;
   logic [2*DW-1:0]  prod_ff;
   logic [2*DW-1:0]  t1_ff;
   logic [2*DW:0]    num_ff;
   logic             neg_ff;
   logic             ovf_ff;
   logic [DW-1:0]    rem_ff;
   logic [DW-1:0]    q_ff;

   logic [AW-1:0]    alu_a;
   logic [AW-1:0]    alu_b;
   logic             alu_sub;
   logic [AW-1:0]    alu_sum;
   logic             alu_borrow;
   logic [DW-1:0]    alu_sat_s;
   logic [DW-1:0]    alu_sat_u;
   logic [2*DW-1:0]  prod_in;
   logic [DW-1:0]    mean_q;
   logic             q_big;

   function automatic logic [DW-1:0] mag_of(input logic [DW-1:0] v);
      logic [DW-1:0] r;
      r = v[DW-1] ? (~v + 1'b1) : v;
      return r;
   endfunction

   // Shared adder: operand select per sequencer state.
   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;
      unique case (state_ff)
         ST_DIFF: begin
            alu_a   = {{(AW-DW){rate_ff[DW-1]}}, rate_ff};
            alu_b   = {{(AW-DW){last_ff[DW-1]}}, last_ff};
            alu_sub = 1'b1;
         end
         ST_MEAN: begin
            alu_a = {{(AW-DW){mean_ff[DW-1]}}, mean_ff};
            alu_b = {{(AW-DW){tmp_ff[DW-1]}}, tmp_ff};
         end
         ST_VAR: begin
            alu_a = {{(AW-DW){1'b0}}, var_ff};
            alu_b = {{(AW-DW){1'b0}}, pv_ff};
         end
         ST_DEN: begin
            alu_a = {{(AW-DW){1'b0}}, var_ff};
            alu_b = {{(AW-DW){1'b0}}, sv_ff};
         end
         ST_MUL: begin
            alu_a = {{(AW-DW){1'b0}}, prod_ff[2*DW-1:DW]};
            alu_b = prod_ff[0] ? {{(AW-DW){1'b0}}, mcand_ff} : '0;
         end
         ST_CMB_A: begin
            alu_a   = {2'b00, t1_ff};
            alu_b   = {2'b00, prod_ff};
            alu_sub = (mean_ff[DW-1] != gyro_ff[DW-1]);
         end
         ST_CMB_B: begin
            alu_a   = {2'b00, prod_ff};
            alu_b   = {2'b00, t1_ff};
            alu_sub = 1'b1;
         end
         ST_DIV_CHK: begin
            alu_a   = {{(AW-DW-1){1'b0}}, num_ff[2*DW:DW]};
            alu_b   = {{(AW-DW){1'b0}}, den_ff};
            alu_sub = 1'b1;
         end
         ST_DIV: begin
            alu_a   = {{(AW-DW-1){1'b0}}, rem_ff, q_ff[DW-1]};
            alu_b   = {{(AW-DW){1'b0}}, den_ff};
            alu_sub = 1'b1;
         end
         default: begin
         end
      endcase
      alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + AW'(alu_sub);
   end

   assign alu_borrow = alu_sum[AW-1];

   always_comb begin
      if ((&alu_sum[AW-1:DW-1]) || ~(|alu_sum[AW-1:DW-1])) begin
         alu_sat_s = alu_sum[DW-1:0];
      end else begin
         alu_sat_s = alu_sum[AW-1] ? SMIN : SMAX;
      end
      alu_sat_u = (|alu_sum[AW-1:DW]) ? '1 : alu_sum[DW-1:0];
   end

   assign prod_in = {alu_sum[DW:0], prod_ff[DW-1:1]};

   // Clamp the mean quotient to the signed range and apply its sign.
   always_comb begin
      if (neg_ff) begin
         q_big  = ovf_ff || (q_ff[DW-1] && (|q_ff[DW-2:0]));
         mean_q = ~(q_big ? SMIN : q_ff) + 1'b1;
      end else begin
         q_big  = ovf_ff || q_ff[DW-1];
         mean_q = q_big ? SMAX : q_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         job_ff        <= JOB_T1;
         cnt_ff        <= '0;
         first_ff      <= 1'b1;
         rsp_tvalid_ff <= 1'b0;
         pv_ff         <= PV_RESET;
         sv_ff         <= SV_RESET;
         iv_ff         <= IV_RESET;
         mean_ff       <= '0;
         var_ff        <= '0;
         last_ff       <= '0;
         gyro_ff       <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               skrf_pkg::CSR_PROCESS_VAR: pv_ff <= csr_wdata;
               skrf_pkg::CSR_SENSOR_VAR:  sv_ff <= csr_wdata;
               skrf_pkg::CSR_INITIAL_VAR: iv_ff <= csr_wdata;
               default: begin
               end
            endcase
         end

         if (rsp_tvalid_ff && rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  rate_ff <= req_tdata[DW-1:0];
                  if (req_tuser == skrf_pkg::CMD_GYRO) begin
                     gyro_ff <= req_tdata[DW-1:0];
                  end else if (first_ff) begin
                     mean_ff  <= req_tdata[DW-1:0];
                     last_ff  <= req_tdata[DW-1:0];
                     var_ff   <= iv_ff;
                     first_ff <= 1'b0;
                  end else begin
                     state_ff <= ST_DIFF;
                  end
               end
            end
            ST_DIFF: begin
               tmp_ff   <= alu_sat_s;
               state_ff <= ST_MEAN;
            end
            ST_MEAN: begin
               mean_ff  <= alu_sat_s;
               last_ff  <= rate_ff;
               state_ff <= ST_VAR;
            end
            ST_VAR: begin
               var_ff   <= alu_sat_u;
               state_ff <= ST_DEN;
            end
            ST_DEN: begin
               den_ff <= alu_sat_u;
               // zero denominator: keep the predicted mean, variance is already zero
               if (alu_sat_u == '0) begin
                  state_ff <= ST_RESULT;
               end else begin
                  mcand_ff <= sv_ff;
                  prod_ff  <= {{DW{1'b0}}, mag_of(mean_ff)};
                  job_ff   <= JOB_T1;
                  cnt_ff   <= LAST_STEP;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               prod_ff <= prod_in;
               if (cnt_ff == '0) begin
                  unique case (job_ff)
                     JOB_T1: begin
                        t1_ff    <= prod_in;
                        mcand_ff <= var_ff;
                        prod_ff  <= {{DW{1'b0}}, mag_of(gyro_ff)};
                        job_ff   <= JOB_T2;
                        cnt_ff   <= LAST_STEP;
                     end
                     JOB_T2: begin
                        state_ff <= ST_CMB_A;
                     end
                     default: begin
                        num_ff   <= {1'b0, prod_in};
                        neg_ff   <= 1'b0;
                        state_ff <= ST_DIV_CHK;
                     end
                  endcase
               end else begin
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            ST_CMB_A: begin
               // same signs add; otherwise subtract the smaller magnitude
               if ((mean_ff[DW-1] == gyro_ff[DW-1]) || !alu_borrow) begin
                  num_ff   <= alu_sum[2*DW:0];
                  neg_ff   <= mean_ff[DW-1];
                  state_ff <= ST_DIV_CHK;
               end else begin
                  state_ff <= ST_CMB_B;
               end
            end
            ST_CMB_B: begin
               num_ff   <= alu_sum[2*DW:0];
               neg_ff   <= gyro_ff[DW-1];
               state_ff <= ST_DIV_CHK;
            end
            ST_DIV_CHK: begin
               // upper half not below the divisor: quotient overflows the word
               if (!alu_borrow) begin
                  ovf_ff   <= 1'b1;
                  state_ff <= ST_DIV_END;
               end else begin
                  ovf_ff   <= 1'b0;
                  rem_ff   <= num_ff[2*DW-1:DW];
                  q_ff     <= num_ff[DW-1:0];
                  cnt_ff   <= LAST_STEP;
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (!alu_borrow) begin
                  rem_ff <= alu_sum[DW-1:0];
               end else begin
                  rem_ff <= {rem_ff[DW-2:0], q_ff[DW-1]};
               end
               q_ff <= {q_ff[DW-2:0], !alu_borrow};
               if (cnt_ff == '0) begin
                  state_ff <= ST_DIV_END;
               end else begin
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            ST_DIV_END: begin
               if (job_ff == JOB_T2) begin
                  mean_ff  <= mean_q;
                  mcand_ff <= var_ff;
                  prod_ff  <= {{DW{1'b0}}, sv_ff};
                  job_ff   <= JOB_T3;
                  cnt_ff   <= LAST_STEP;
                  state_ff <= ST_MUL;
               end else begin
                  var_ff   <= ovf_ff ? '1 : q_ff;
                  state_ff <= ST_RESULT;
               end
            end
            ST_RESULT: begin
               // hold until the output register is free
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tvalid_ff <= 1'b1;
                  fused_ff      <= mean_ff;
                  evar_ff       <= var_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = OW'({evar_ff, fused_ff});

   // The first odometry beat never leaves the idle state.
   a_first_idle : assert property (@(posedge clock) disable iff (reset)
      first_ff |-> (state_ff == ST_IDLE))
      else $error("sequencer busy before the filter was seeded");

   // Restoring divide keeps its remainder below the divisor.
   a_rem_bound : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < den_ff))
      else $error("divide remainder not below divisor");

   // A new result is loaded only from the result state.
   a_result_src : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && !$past(rsp_tvalid_ff) && !$past(reset)) |->
         ($past(state_ff) == ST_RESULT))
      else $error("result raised outside the result state");

   // Gyro beats never start the sequencer.
   a_gyro_idle : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == skrf_pkg::CMD_GYRO)) |=>
         (state_ff == ST_IDLE))
      else $error("gyro beat started a filter step");

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// Self-checking bench for the scalar Kalman rate fusion block: table, random stream, predictor.
`timescale 1ns / 1ps

module tb_top;

   localparam int          CYCLE_LIMIT   = 1_500_000;
   localparam int          SETTLE_CYCLES = 200;
   localparam int          PHASES        = 6;
   localparam int          PHASE_BEATS   = 230;
   localparam logic [31:0] RATE_MAX      = 32'h7FFF_FFFF;
   localparam logic [31:0] RATE_MIN      = 32'h8000_0000;
   localparam logic [31:0] RATE_ONE      = 32'h0001_0000;
   localparam logic [31:0] VAR_MAX       = 32'hFFFF_FFFF;
   localparam skrf_pkg::csr_idx_type CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [31:0] variance;
      logic [31:0] rate;
   } fusion_type;

   typedef enum logic {ROW_BEAT, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      logic                  cmd;
      skrf_pkg::csr_idx_type addr;
      logic [31:0]           data;
      logic                  typed;
      fusion_type            want;
   } plan_row_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;  // angular_rate
   logic        req_tuser  = skrf_pkg::CMD_GYRO;  // cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;  // fused_rate, estimate_variance
   logic        csr_we     = 1'b0;
   skrf_pkg::csr_idx_type csr_addr = skrf_pkg::CSR_PROCESS_VAR;
   logic [31:0] csr_wdata  = '0;

   scalar_kalman_rate_fusion dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // filter shadow state
   logic [31:0] reg_process_var = 32'h0004_0000;
   logic [31:0] reg_sensor_var  = 32'h0000_8000;
   logic [31:0] reg_initial_var = 32'h03E8_0000;
   longint      est_mean        = 0;
   logic [31:0] est_var         = '0;
   longint      prev_odometry   = 0;
   longint      gyro_hold       = 0;
   bit          seeding         = 1'b1;

   fusion_type   fused_q[$];
   plan_row_type plan[$];
   int unsigned mismatches = 0;
   int unsigned cycles     = 0;
   bit          steady     = 1'b0;
   bit          in_flight  = 1'b0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin : watchdog
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic longint clamp_rate(input longint v);
      if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
      if (v < -64'sh8000_0000) return -64'sh8000_0000;
      return v;
   endfunction

   function automatic logic [31:0] clamp_var(input logic [32:0] v);
      return v[32] ? VAR_MAX : v[31:0];
   endfunction

   // Predict with the odometry delta, then blend toward the held gyro rate.
   task automatic kalman_fuse(input logic cmd, input logic [31:0] sample,
                              output bit fired, output fusion_type res);
      longint             rate_now;
      logic [31:0]        denom;
      logic signed [127:0] num;
      logic [127:0]       mag;
      logic [127:0]       quot;
      rate_now = longint'($signed(sample));
      fired = 1'b0;
      res = '0;
      if (cmd == skrf_pkg::CMD_GYRO) begin
         gyro_hold = rate_now;
      end else if (seeding) begin
         est_mean = rate_now;
         prev_odometry = rate_now;
         est_var = reg_initial_var;
         seeding = 1'b0;
      end else begin
         est_mean = clamp_rate(est_mean + clamp_rate(rate_now - prev_odometry));
         est_var = clamp_var({1'b0, est_var} + reg_process_var);
         denom = clamp_var({1'b0, est_var} + reg_sensor_var);
         // both variances zero: keep the predicted mean
         if (denom != '0) begin
            num = $signed({96'd0, reg_sensor_var}) * est_mean
                + $signed({96'd0, est_var}) * gyro_hold;
            mag = (num < 0) ? -num : num;
            quot = mag / {96'd0, denom};
            if (num < 0) begin
               if (quot > 128'h8000_0000) quot = 128'h8000_0000;
               est_mean = -longint'(quot[63:0]);
            end else begin
               if (quot > 128'h7FFF_FFFF) quot = 128'h7FFF_FFFF;
               est_mean = longint'(quot[63:0]);
            end
            quot = ({96'd0, est_var} * {96'd0, reg_sensor_var}) / {96'd0, denom};
            est_var = (quot > 128'hFFFF_FFFF) ? VAR_MAX : quot[31:0];
         end
         prev_odometry = rate_now;
         fired = 1'b1;
         res.rate = est_mean[31:0];
         res.variance = est_var;
      end
   endtask

   task automatic flag_mismatch(input string what);
      if (mismatches < 50) $display("mismatch at %0t: %s", $time, what);
      mismatches++;
   endtask

   always @(posedge clock) begin : check_fused
      fusion_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (fused_q.size() == 0) begin
               flag_mismatch($sformatf("unexpected beat %h", rsp_tdata));
            end else begin
               want = fused_q.pop_front();
               if (rsp_tdata[31:0] !== want.rate)
                  flag_mismatch($sformatf("fused_rate %h, want %h",
                                          rsp_tdata[31:0], want.rate));
               if (rsp_tdata[63:32] !== want.variance)
                  flag_mismatch($sformatf("estimate_variance %h, want %h",
                                          rsp_tdata[63:32], want.variance));
            end
         end
         rsp_tready <= steady || ($urandom_range(99) >= 35);
      end
   end

   function automatic plan_row_type beat_row(input logic cmd, input logic [31:0] data);
      plan_row_type r;
      r = '0;
      r.kind = ROW_BEAT;
      r.cmd = cmd;
      r.data = data;
      return r;
   endfunction

   function automatic plan_row_type typed_row(input logic [31:0] data,
                                              input logic [31:0] rate,
                                              input logic [31:0] variance);
      plan_row_type r;
      r = beat_row(skrf_pkg::CMD_ODOMETRY, data);
      r.typed = 1'b1;
      r.want.rate = rate;
      r.want.variance = variance;
      return r;
   endfunction

   function automatic plan_row_type csr_row(input skrf_pkg::csr_idx_type addr,
                                            input logic [31:0] data);
      plan_row_type r;
      r = '0;
      r.kind = ROW_CSR;
      r.addr = addr;
      r.data = data;
      return r;
   endfunction

   function automatic logic [31:0] pick_rate(input logic [31:0] near);
      if ($urandom_range(9) < 3) return $urandom;
      return near + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
   endfunction

   function automatic logic [31:0] pick_variance(input int unsigned floor);
      case ($urandom_range(3))
         0:       return floor;
         1:       return VAR_MAX;
         2:       return $urandom_range(floor, 32'h0010_0000);
         default: return $urandom_range(floor, VAR_MAX);
      endcase
   endfunction

   task automatic push_beat(input logic cmd, input logic [31:0] data, input logic typed,
                            input fusion_type typed_want);
      bit         fired;
      fusion_type got;
      // idle each cycle with the same odds before offering the beat
      while (!steady && $urandom_range(99) < 35) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      kalman_fuse(cmd, data, fired, got);
      if (fired) fused_q.push_back(typed ? typed_want : got);
      in_flight = 1'b1;
   endtask

   // Wait out every pending result plus the sequencer's tail.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (fused_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      in_flight = 1'b0;
   endtask

   task automatic write_register(input skrf_pkg::csr_idx_type addr, input logic [31:0] data);
      if (in_flight) drain();
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (addr)
         skrf_pkg::CSR_PROCESS_VAR: reg_process_var = data;
         skrf_pkg::CSR_SENSOR_VAR:  reg_sensor_var  = data;
         skrf_pkg::CSR_INITIAL_VAR: reg_initial_var = data;
         default: ;
      endcase
   endtask

   initial begin : stimulus
      logic [31:0] sample;
      logic [31:0] pv;
      logic [31:0] sv;

      // reset defaults; first odometry seeds before any gyro arrives
      plan.push_back(beat_row(skrf_pkg::CMD_ODOMETRY, RATE_ONE));
      plan.push_back(beat_row(skrf_pkg::CMD_ODOMETRY, RATE_ONE));
      plan.push_back(beat_row(skrf_pkg::CMD_GYRO, RATE_MAX));
      plan.push_back(beat_row(skrf_pkg::CMD_ODOMETRY, RATE_MAX));
      plan.push_back(beat_row(skrf_pkg::CMD_ODOMETRY, RATE_MIN));
      plan.push_back(beat_row(skrf_pkg::CMD_GYRO, RATE_MIN));
      plan.push_back(beat_row(skrf_pkg::CMD_ODOMETRY, RATE_MAX));
      plan.push_back(beat_row(skrf_pkg::CMD_ODOMETRY, '0));
      // saturated variance and denominator
      plan.push_back(csr_row(skrf_pkg::CSR_PROCESS_VAR, VAR_MAX));
      plan.push_back(csr_row(skrf_pkg::CSR_SENSOR_VAR, VAR_MAX));
      plan.push_back(csr_row(skrf_pkg::CSR_INITIAL_VAR, VAR_MAX));
      plan.push_back(beat_row(skrf_pkg::CMD_GYRO, 32'h1234_5678));
      plan.push_back(beat_row(skrf_pkg::CMD_ODOMETRY, 32'hFFFF_FFFF));
      plan.push_back(beat_row(skrf_pkg::CMD_ODOMETRY, RATE_MAX));
      plan.push_back(beat_row(skrf_pkg::CMD_GYRO, RATE_MIN));
      plan.push_back(beat_row(skrf_pkg::CMD_ODOMETRY, RATE_MIN));
      // zero sensor noise: snap to gyro, then the denominator goes to zero
      plan.push_back(csr_row(skrf_pkg::CSR_PROCESS_VAR, '0));
      plan.push_back(csr_row(skrf_pkg::CSR_SENSOR_VAR, '0));
      plan.push_back(csr_row(CSR_UNUSED, VAR_MAX));
      plan.push_back(beat_row(skrf_pkg::CMD_GYRO, RATE_MAX));
      plan.push_back(typed_row('0, RATE_MAX, '0));
      plan.push_back(typed_row(RATE_MAX, RATE_MAX, '0));
      plan.push_back(typed_row(RATE_MIN, 32'hFFFF_FFFF, '0));
      plan.push_back(typed_row(RATE_MAX, 32'h7FFF_FFFE, '0));
      plan.push_back(typed_row(RATE_MIN, 32'hFFFF_FFFE, '0));
      plan.push_back(typed_row('0, 32'h7FFF_FFFD, '0));
      // unit process noise with zero sensor noise: mean becomes the gyro rate exactly
      plan.push_back(csr_row(skrf_pkg::CSR_PROCESS_VAR, RATE_ONE));
      plan.push_back(beat_row(skrf_pkg::CMD_GYRO, RATE_MIN));
      plan.push_back(typed_row(32'h0000_0005, RATE_MIN, '0));

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR)
            write_register(plan[i].addr, plan[i].data);
         else
            push_beat(plan[i].cmd, plan[i].data, plan[i].typed, plan[i].want);
      end

      sample = '0;
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               pv = 32'h0004_0000;
               sv = 32'h0000_8000;
            end
            1: begin
               pv = '0;
               sv = 32'h0000_0001;
            end
            2: begin
               pv = VAR_MAX;
               sv = VAR_MAX;
            end
            default: begin
               pv = pick_variance(0);
               sv = pick_variance(1);
            end
         endcase
         write_register(skrf_pkg::CSR_PROCESS_VAR, pv);
         write_register(skrf_pkg::CSR_SENSOR_VAR, sv);
         write_register(skrf_pkg::CSR_INITIAL_VAR, $urandom);
         // one whole phase runs with both sides never idling
         steady = (phase == 3);
         for (int n = 0; n < PHASE_BEATS; n++) begin
            sample = pick_rate(sample);
            push_beat(logic'($urandom_range(1)), sample, 1'b0, '0);
         end
         steady = 1'b0;
      end

      drain();
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
